FILE: rtl/swstat_pkg.sv
// Shared widths, controller commands and datapath status for the window statistics block.
package swstat_pkg;

    // Window depth and derived counter widths
    localparam int WINDOW   = 10;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SLOT_W   = $clog2(WINDOW);

    // Field widths
    localparam int SAMPLE_W = 15;
    localparam int TD_W     = 31;
    localparam int MEAN_W   = 23;
    localparam int VAR_W    = 36;
    localparam int DEV_W    = 22;
    localparam int DIFF_W   = 16;

    // Running sums and the variance numerator
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int SQ_W     = 2 * SAMPLE_W + CNT_W;
    localparam int NUM_W    = SQ_W + CNT_W;

    // Radix-16 divider: four quotient bits per cycle
    localparam int DIV_DIG  = 4;
    localparam int DIV_W    = 2 * CNT_W;
    localparam int MEAN_IT  = (SUM_W + 8 + DIV_DIG - 1) / DIV_DIG;
    localparam int VAR_IT   = (NUM_W + 16 + DIV_DIG - 1) / DIV_DIG;
    localparam int MEAN_DW  = MEAN_IT * DIV_DIG;
    localparam int DVD_W    = VAR_IT * DIV_DIG;

    // Square root: one result bit per cycle
    localparam int SQRT_IT  = DEV_W;
    localparam int SQIN_W   = 2 * DEV_W;
    localparam int SREM_W   = DEV_W + 2;

    localparam int ITER_W   = $clog2(MEAN_IT + VAR_IT + SQRT_IT);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic square;
        logic update;
        logic product;
        logic numer;
        logic div_mean;
        logic div_var;
        logic div_step;
        logic mean_take;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic item_bad;
    } t_stat;

endpackage

FILE: rtl/swstat_dp.sv
// Datapath: window store, running sums, divider, square root and result registers.
module swstat_dp
    import swstat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic signed [15:0]       i_sample,
    input  logic signed [31:0]       i_elapsed,
    output logic                     o_valid_res,
    output logic [TD_W-1:0]          o_elapsed_out,
    output logic [SAMPLE_W-1:0]      o_sample_out,
    output logic [MEAN_W-1:0]        o_mean_q8,
    output logic [VAR_W-1:0]         o_variance_q8,
    output logic [DEV_W-1:0]         o_deviation_q8,
    output logic signed [DIFF_W-1:0] o_difference
);

    // Window store
    logic [SAMPLE_W-1:0]  r_store [WINDOW];

    // State with a reset value
    logic [CNT_W-1:0]     r_cnt;
    logic [SLOT_W-1:0]    r_slot;
    logic [SUM_W-1:0]     r_sum;
    logic [SQ_W-1:0]      r_sq;
    logic [SAMPLE_W-1:0]  r_prev;

    // Working registers
    logic                 r_bad;
    logic [SAMPLE_W-1:0]  r_s;
    logic [TD_W-1:0]      r_td;
    logic [SAMPLE_W-1:0]  r_old;
    logic [2*SAMPLE_W-1:0] r_s2;
    logic [2*SAMPLE_W-1:0] r_o2;
    logic [DIFF_W-1:0]    r_diff;
    logic [NUM_W-1:0]     r_nq;
    logic [NUM_W-1:0]     r_ss;
    logic [DIV_W-1:0]     r_nn;
    logic [NUM_W-1:0]     r_num;
    logic [DVD_W-1:0]     r_q;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dsr;
    logic [MEAN_W-1:0]    r_mean;
    logic [VAR_W-1:0]     r_var;
    logic [SQIN_W-1:0]    r_x;
    logic [SREM_W-1:0]    r_srem;
    logic [DEV_W-1:0]     r_root;

    // Result registers
    logic                 r_o_valid_res;
    logic [TD_W-1:0]      r_o_td;
    logic [SAMPLE_W-1:0]  r_o_s;
    logic [MEAN_W-1:0]    r_o_mean;
    logic [VAR_W-1:0]     r_o_var;
    logic [DEV_W-1:0]     r_o_dev;
    logic [DIFF_W-1:0]    r_o_diff;

    logic                 full;
    logic [SLOT_W-1:0]    n_slot;
    logic [SUM_W-1:0]     n_sum;
    logic [SQ_W-1:0]      n_sq;
    logic [DVD_W-1:0]     n_q;
    logic [DIV_W-1:0]     n_rem;
    logic [SREM_W-1:0]    n_srem;
    logic [DEV_W-1:0]     n_root;

    assign o_stat.item_bad = i_sample[15] | i_elapsed[31];
    assign full            = (r_cnt == CNT_W'(WINDOW));

    // Next sums and slot for the push
    always_comb begin
        n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
        if (full) begin
            n_sum = r_sum - SUM_W'(r_old) + SUM_W'(r_s);
            n_sq  = r_sq - SQ_W'(r_o2) + SQ_W'(r_s2);
        end else begin
            n_sum = r_sum + SUM_W'(r_s);
            n_sq  = r_sq + SQ_W'(r_s2);
        end
    end

    // Four restoring division steps per cycle
    always_comb begin
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] rem_v;
        logic [DVD_W-1:0] q_v;
        rem_v = r_rem;
        q_v   = r_q;
        for (int k = 0; k < DIV_DIG; k++) begin
            t   = {rem_v, q_v[DVD_W-1]};
            q_v = {q_v[DVD_W-2:0], 1'b0};
            if (t >= {1'b0, r_dsr}) begin
                t      = t - {1'b0, r_dsr};
                q_v[0] = 1'b1;
            end
            rem_v = t[DIV_W-1:0];
        end
        n_q   = q_v;
        n_rem = rem_v;
    end

    // One square root step: bring down two bits, try root*4+1
    always_comb begin
        logic [SREM_W+1:0] sh;
        logic [SREM_W+1:0] trial;
        sh    = {r_srem, r_x[SQIN_W-1 -: 2]};
        trial = (SREM_W + 2)'({r_root, 2'b01});
        if (sh >= trial) begin
            sh     = sh - trial;
            n_root = {r_root[DEV_W-2:0], 1'b1};
        end else begin
            n_root = {r_root[DEV_W-2:0], 1'b0};
        end
        n_srem = sh[SREM_W-1:0];
    end

    // Window state: cleared at reset, advanced on each pushed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_slot <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_prev <= '0;
        end else if (i_cmd.update) begin
            if (!full) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_slot <= n_slot;
            r_sum  <= n_sum;
            r_sq   <= n_sq;
            r_prev <= r_s;
        end
    end

    // Window store write and registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_store[r_slot] <= r_s;
        end
        if (i_cmd.capture) begin
            r_old <= r_store[r_slot];
        end
    end

    // Payload pipeline of one item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bad <= o_stat.item_bad;
            r_s   <= i_sample[SAMPLE_W-1:0];
            r_td  <= i_elapsed[TD_W-1:0];
        end
        if (i_cmd.square) begin
            r_s2 <= (2*SAMPLE_W)'(r_s) * (2*SAMPLE_W)'(r_s);
            r_o2 <= (2*SAMPLE_W)'(r_old) * (2*SAMPLE_W)'(r_old);
        end
        if (i_cmd.update) begin
            r_diff <= (r_cnt != '0) ? ({1'b0, r_s} - {1'b0, r_prev}) : '0;
        end
        if (i_cmd.product) begin
            r_nq <= NUM_W'(r_cnt) * NUM_W'(r_sq);
            r_ss <= NUM_W'(r_sum) * NUM_W'(r_sum);
            r_nn <= DIV_W'(r_cnt) * DIV_W'(r_cnt);
        end
        if (i_cmd.numer) begin
            r_num <= r_nq - r_ss;
        end
        // Divider: load mean or variance operands, else step
        if (i_cmd.div_mean) begin
            r_q   <= {MEAN_DW'({r_sum, 8'b0}), (DVD_W - MEAN_DW)'(0)};
            r_rem <= '0;
            r_dsr <= DIV_W'(r_cnt);
        end else if (i_cmd.div_var) begin
            r_q   <= DVD_W'({r_num, 16'b0});
            r_rem <= '0;
            r_dsr <= r_nn;
        end else if (i_cmd.div_step) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
        if (i_cmd.mean_take) begin
            r_mean <= r_q[MEAN_W-1:0];
        end
        // Square root: load the scaled quotient, else step
        if (i_cmd.sqrt_load) begin
            r_var  <= r_q[8 +: VAR_W];
            r_x    <= r_q[SQIN_W-1:0];
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_x    <= {r_x[SQIN_W-3:0], 2'b00};
            r_srem <= n_srem;
            r_root <= n_root;
        end
        // Result registers, zero for a rejected beat
        if (i_cmd.out_load) begin
            if (r_bad) begin
                r_o_valid_res <= 1'b0;
                r_o_td        <= '0;
                r_o_s         <= '0;
                r_o_mean      <= '0;
                r_o_var       <= '0;
                r_o_dev       <= '0;
                r_o_diff      <= '0;
            end else begin
                r_o_valid_res <= 1'b1;
                r_o_td        <= r_td;
                r_o_s         <= r_s;
                r_o_mean      <= r_mean;
                r_o_var       <= r_var;
                r_o_dev       <= r_root;
                r_o_diff      <= r_diff;
            end
        end
    end

    assign o_valid_res      = r_o_valid_res;
    assign o_elapsed_out    = r_o_td;
    assign o_sample_out     = r_o_s;
    assign o_mean_q8        = r_o_mean;
    assign o_variance_q8    = r_o_var;
    assign o_deviation_q8   = r_o_dev;
    assign o_difference     = r_o_diff;

endmodule

FILE: rtl/swstat_ctrl.sv
// Controller: sequences capture, update, products, divisions, square root and result hand-off.
module swstat_ctrl
    import swstat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_UPD,
        S_MUL2,
        S_NUM,
        S_DIVM,
        S_VLOAD,
        S_DIVV,
        S_SLOAD,
        S_SQRT,
        S_OUT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [ITER_W-1:0] r_iter;
    logic [ITER_W-1:0] n_iter;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              in_beat;
    logic              out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Decode state into datapath commands and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_stat.item_bad ? S_OUT : S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.square = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.product = 1'b1;
                n_state       = S_NUM;
            end
            S_NUM: begin
                o_cmd.numer    = 1'b1;
                o_cmd.div_mean = 1'b1;
                n_iter         = '0;
                n_state        = S_DIVM;
            end
            S_DIVM: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == ITER_W'(MEAN_IT - 1)) begin
                    n_state = S_VLOAD;
                end
            end
            S_VLOAD: begin
                o_cmd.mean_take = 1'b1;
                o_cmd.div_var   = 1'b1;
                n_iter          = '0;
                n_state         = S_DIVV;
            end
            S_DIVV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == ITER_W'(VAR_IT - 1)) begin
                    n_state = S_SLOAD;
                end
            end
            S_SLOAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_iter          = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_iter          = r_iter + 1'b1;
                if (r_iter == ITER_W'(SQRT_IT - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the result register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, iteration count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/sliding_window_statistics.sv
// Sliding window statistics: top level joining controller and datapath.
//
// Input channel i_in_valid / o_in_ready carries one beat of i_sample and
// i_elapsed. Output channel o_out_valid / i_out_ready carries one result
// beat per input beat, in order.
// A beat with a negative sample or time delta is rejected: its result has
// o_valid_res low and all other fields zero, and the window is untouched.
// An accepted beat is pushed into the window (oldest sample dropped once
// full) and gives mean, variance, deviation and difference over the held
// samples, with the sample and time delta passed through.
// An accepted beat runs through square, update, products, numerator,
// radix-16 mean division, variance load, variance division, square root
// load, bit-serial square root and result load; a rejected beat goes
// straight to the result load. One beat is in work at a time, so the next
// input beat is taken only once the last one reaches the result register;
// the shared divider and the bit-serial square root set this pace.
// The result sits in an output register: the next input beat is taken while
// it waits, and a stalled receiver holds the next finished beat in its last
// step until the register is free.
// Reset (synchronous, active low) empties the window and clears the sums;
// no result is pending afterward.
module sliding_window_statistics
    import swstat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [15:0]       i_sample,
    input  logic signed [31:0]       i_elapsed,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_valid_res,
    output logic [TD_W-1:0]          o_elapsed_out,
    output logic [SAMPLE_W-1:0]      o_sample_out,
    output logic [MEAN_W-1:0]        o_mean_q8,
    output logic [VAR_W-1:0]         o_variance_q8,
    output logic [DEV_W-1:0]         o_deviation_q8,
    output logic signed [DIFF_W-1:0] o_difference
);

    t_cmd  cmd;
    t_stat stat;

    swstat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    swstat_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample         (i_sample),
        .i_elapsed        (i_elapsed),
        .o_valid_res      (o_valid_res),
        .o_elapsed_out    (o_elapsed_out),
        .o_sample_out     (o_sample_out),
        .o_mean_q8        (o_mean_q8),
        .o_variance_q8    (o_variance_q8),
        .o_deviation_q8   (o_deviation_q8),
        .o_difference     (o_difference)
    );

`ifndef SYNTHESIS
    // A rejected beat carries only zeros
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |->
            (o_elapsed_out == '0 && o_sample_out == '0 && o_mean_q8 == '0 &&
             o_variance_q8 == '0 && o_deviation_q8 == '0 && o_difference == '0))
        else $error("rejected beat with nonzero fields");

    // Deviation squared never exceeds the scaled variance
    a_dev_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |->
            ((SQIN_W'(o_deviation_q8) * SQIN_W'(o_deviation_q8)) <=
             {o_variance_q8, 8'hff}))
        else $error("deviation exceeds square root of variance");

    // Input is closed right after a beat is taken
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second input beat taken while busy");
`endif

endmodule

FILE: tb/sv/window_stats_checker.sv
`timescale 1ns / 1ps
// Checker for the window statistics block: predicts every result beat and compares it.
module window_stats_checker
    import swstat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic signed [15:0]       i_sample,
    input  logic signed [31:0]       i_elapsed,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_valid_res,
    input  logic [TD_W-1:0]          i_elapsed_out,
    input  logic [SAMPLE_W-1:0]      i_sample_out,
    input  logic [MEAN_W-1:0]        i_mean_q8,
    input  logic [VAR_W-1:0]         i_variance_q8,
    input  logic [DEV_W-1:0]         i_deviation_q8,
    input  logic signed [DIFF_W-1:0] i_difference,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results_checked
);

    typedef struct packed {
        logic                     valid_res;
        logic [TD_W-1:0]          elapsed;
        logic [SAMPLE_W-1:0]      sample;
        logic [MEAN_W-1:0]        mean;
        logic [VAR_W-1:0]         variance;
        logic [DEV_W-1:0]         deviation;
        logic signed [DIFF_W-1:0] difference;
    } t_stats_beat;

    // Result beats still owed by the block, oldest first
    t_stats_beat expected_stats[$];

    // Mirror of the window contents and running sums
    logic [SAMPLE_W-1:0] held_samples [WINDOW];
    int unsigned         held_count;
    int unsigned         next_slot;
    logic [63:0]         sample_sum;
    logic [63:0]         square_sum;
    logic [SAMPLE_W-1:0] last_sample;

    int fail_count      = 0;
    int pending_count   = 0;
    int results_checked = 0;

    assign o_fail_count      = fail_count;
    assign o_pending         = pending_count;
    assign o_results_checked = results_checked;

    // Settle the root one bit at a time from the top; the argument stays below 2^60
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 30; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Push one sample into the mirrored window and work out its result beat
    function automatic t_stats_beat push_sample(input logic signed [15:0] smp,
                                                input logic signed [31:0] td);
        t_stats_beat beat;
        logic [63:0] s;
        logic [63:0] oldest;
        logic [63:0] n;
        logic [63:0] spread;
        beat = '0;
        // Reject a negative sample or time delta, window untouched
        if (smp < 0 || td < 0)
            return beat;
        s = 64'(smp[SAMPLE_W-1:0]);
        if (held_count == WINDOW) begin
            oldest      = 64'(held_samples[next_slot]);
            sample_sum  = sample_sum - oldest;
            square_sum  = square_sum - oldest * oldest;
        end else begin
            held_count++;
        end
        held_samples[next_slot] = smp[SAMPLE_W-1:0];
        sample_sum = sample_sum + s;
        square_sum = square_sum + s * s;
        next_slot  = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;

        n      = 64'(held_count);
        spread = n * square_sum - sample_sum * sample_sum;
        beat.valid_res  = 1'b1;
        beat.elapsed    = td[TD_W-1:0];
        beat.sample     = smp[SAMPLE_W-1:0];
        beat.mean       = MEAN_W'((sample_sum << 8) / n);
        beat.variance   = VAR_W'((spread << 8) / (n * n));
        beat.deviation  = DEV_W'(floor_sqrt((spread << 16) / (n * n)));
        beat.difference = (n >= 2) ? DIFF_W'(s - 64'(last_sample)) : '0;
        last_sample     = smp[SAMPLE_W-1:0];
        return beat;
    endfunction

    // Count a field mismatch; report only the first few
    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t checker: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // Compare output beats, then predict from input beats taken at the same edge
    always @(posedge i_clk) begin : watch_channels
        t_stats_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++)
                held_samples[i] = '0;
            held_count  = 0;
            next_slot   = 0;
            sample_sum  = '0;
            square_sum  = '0;
            last_sample = '0;
            expected_stats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_stats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t checker: result beat with nothing expected", $time);
                end else begin
                    want = expected_stats[0];
                    expected_stats.delete(0);
                    results_checked++;
                    check_field("valid_res", 64'(want.valid_res), 64'(i_valid_res));
                    check_field("elapsed_out", 64'(want.elapsed),
                                64'(i_elapsed_out));
                    check_field("sample_out", 64'(want.sample), 64'(i_sample_out));
                    check_field("mean_q8", 64'(want.mean), 64'(i_mean_q8));
                    check_field("variance_q8", 64'(want.variance), 64'(i_variance_q8));
                    check_field("deviation_q8", 64'(want.deviation), 64'(i_deviation_q8));
                    check_field("difference", 64'(want.difference), 64'(i_difference));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_stats.insert(expected_stats.size(),
                                      push_sample(i_sample, i_elapsed));
        end
        pending_count = expected_stats.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the window statistics block: clock, reset, stimulus and verdict.
module tb
    import swstat_pkg::*;
;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BEATS = 1550;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_PCT     = 19;

    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic signed [15:0]       i_sample     = '0;
    logic signed [31:0]       i_elapsed    = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic                     o_valid_res;
    logic [TD_W-1:0]          o_elapsed_out;
    logic [SAMPLE_W-1:0]      o_sample_out;
    logic [MEAN_W-1:0]        o_mean_q8;
    logic [VAR_W-1:0]         o_variance_q8;
    logic [DEV_W-1:0]         o_deviation_q8;
    logic signed [DIFF_W-1:0] o_difference;

    int cycle_count    = 0;
    int beats_sent     = 0;
    int beats_rejected = 0;
    int fail_count;
    int pending_count;
    int results_checked;

    // Neither side idles inside this stretch of beats
    logic steady_stretch;
    assign steady_stretch = (beats_sent >= 700) && (beats_sent < 1000);

    sliding_window_statistics DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .i_elapsed        (i_elapsed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_valid_res      (o_valid_res),
        .o_elapsed_out    (o_elapsed_out),
        .o_sample_out     (o_sample_out),
        .o_mean_q8        (o_mean_q8),
        .o_variance_q8    (o_variance_q8),
        .o_deviation_q8   (o_deviation_q8),
        .o_difference     (o_difference)
    );

    window_stats_checker CHECK (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_sample          (i_sample),
        .i_elapsed         (i_elapsed),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_valid_res       (o_valid_res),
        .i_elapsed_out     (o_elapsed_out),
        .i_sample_out      (o_sample_out),
        .i_mean_q8         (o_mean_q8),
        .i_variance_q8     (o_variance_q8),
        .i_deviation_q8    (o_deviation_q8),
        .i_difference      (o_difference),
        .o_fail_count      (fail_count),
        .o_pending         (pending_count),
        .o_results_checked (results_checked)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // End the run if the block hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // Stall the result channel at random outside the steady stretch
    always @(negedge i_clk) begin
        i_out_ready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one input beat after a random gap and hold it until taken
    task automatic send_beat(input logic signed [15:0] smp, input logic signed [31:0] td);
        int gap;
        gap = 0;
        if (!steady_stretch) begin
            if ($urandom_range(0, 11) == 0)
                gap = $urandom_range(1, 70);
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        end
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sample     <= smp;
        i_elapsed    <= td;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        beats_sent++;
        if (smp < 0 || td < 0)
            beats_rejected++;
        @(negedge i_clk);
    endtask

    initial begin
        int                 k;
        int                 burst_left;
        int                 mode;
        logic signed [15:0] smp;
        logic signed [31:0] td;
        logic [14:0]        hold_value;

        burst_left = 0;
        mode       = 0;
        hold_value = '0;

        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, rejected beats, sign flips of the difference, window wrap
        send_beat(16'sd0, 32'sd0);
        send_beat(-16'sd1, 32'sd5);
        send_beat(16'sd32767, 32'sh7FFF_FFFF);
        send_beat(16'sd0, 32'sd1);
        send_beat(16'sd32767, 32'sd0);
        send_beat(16'sd100, -32'sd1);
        send_beat(16'sh8000, 32'sh8000_0000);
        for (k = 0; k < 10; k++)
            send_beat(k[0] ? 16'sd32767 : 16'sd0, 32'(k * 1000));
        send_beat(16'sd12345, 32'sh4000_0000);
        send_beat(16'sd1, 32'sd1);

        // Random: bursts of well-formed sample patterns with some rejected noise
        for (k = 0; k < RANDOM_BEATS; k++) begin
            if (burst_left == 0) begin
                mode       = $urandom_range(0, 5);
                burst_left = $urandom_range(1, 24);
                hold_value = 15'($urandom);
            end
            burst_left--;
            case (mode)
                0: smp = {1'b0, 15'($urandom)};
                1: smp = 16'($urandom_range(0, 7));
                2: smp = 16'($urandom_range(32700, 32767));
                3: smp = {1'b0, hold_value};
                4: smp = k[0] ? 16'sd32767 : 16'sd0;
                default: smp = 16'($urandom_range(0, 300));
            endcase
            if ($urandom_range(0, 3) == 0)
                td = 32'($urandom_range(0, 1000));
            else
                td = {1'b0, 31'($urandom)};
            // Flip sign bits on a few beats so they get rejected
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 2))
                    0: smp = {1'b1, 15'($urandom)};
                    1: td[31] = 1'b1;
                    default: begin
                        smp[15] = 1'b1;
                        td[31]  = 1'b1;
                    end
                endcase
            end
            send_beat(smp, td);
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d input beats sent, %0d of them rejected, %0d result beats checked",
                 beats_sent, beats_rejected, results_checked);
        $display("tb: window of %0d wrapped many times under random stalls on both sides",
                 WINDOW);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
